### rtl/iat_pkg.sv
// ----------------------------------------------------------------------------
// iat_pkg
// Shared widths, request and kind codes and the range entry type of the
// interval attribute table.
// ----------------------------------------------------------------------------
package iat_pkg;

   localparam int MAX_RANGES  = 32;
   localparam int IDX_BITS    = $clog2(MAX_RANGES);
   localparam int CNT_BITS    = $clog2(MAX_RANGES + 1);
   localparam int POS_BITS    = 16;
   localparam int AUTHOR_BITS = 8;
   localparam int STAMP_BITS  = 32;
   localparam int KIND_BITS   = 2;
   localparam int REQ_BITS    = 3;

   localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

   // request codes
   localparam logic [REQ_BITS-1:0] REQ_SET    = 3'd0;
   localparam logic [REQ_BITS-1:0] REQ_INSERT = 3'd1;
   localparam logic [REQ_BITS-1:0] REQ_ERASE  = 3'd2;
   localparam logic [REQ_BITS-1:0] REQ_LOOKUP = 3'd3;
   localparam logic [REQ_BITS-1:0] REQ_TEST   = 3'd4;

   // change kind codes
   localparam logic [KIND_BITS-1:0] KIND_NONE     = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_RESERVED = 2'd3;

   typedef struct packed {
      logic [POS_BITS-1:0]    lo;
      logic [POS_BITS-1:0]    hi;
      logic [KIND_BITS-1:0]   kind;
      logic [AUTHOR_BITS-1:0] who;
      logic [STAMP_BITS-1:0]  stamp;
   } span_type;

endpackage

### rtl/iat_req_if.sv
// ----------------------------------------------------------------------------
// iat_req_if
// Request channel of the interval attribute table.
// ----------------------------------------------------------------------------
interface iat_req_if import iat_pkg::*; ;
   logic                   valid;
   logic                   ready;
   logic [REQ_BITS-1:0]    req_type;
   logic [POS_BITS-1:0]    range_first;
   logic [POS_BITS-1:0]    range_last;
   logic [KIND_BITS-1:0]   change_kind;
   logic [AUTHOR_BITS-1:0] change_author;
   logic [STAMP_BITS-1:0]  change_stamp;

   modport source (output valid, req_type, range_first, range_last, change_kind,
                   change_author, change_stamp, input ready);
   modport sink   (input valid, req_type, range_first, range_last, change_kind,
                   change_author, change_stamp, output ready);
endinterface

### rtl/iat_rsp_if.sv
// ----------------------------------------------------------------------------
// iat_rsp_if
// Response channel of the interval attribute table.
// ----------------------------------------------------------------------------
interface iat_rsp_if import iat_pkg::*; ;
   logic                   valid;
   logic                   ready;
   logic [KIND_BITS-1:0]   found_kind;
   logic [AUTHOR_BITS-1:0] found_author;
   logic [STAMP_BITS-1:0]  found_stamp;
   logic                   overlap_seen;
   logic                   overflow;
   logic [CNT_BITS-1:0]    entries_used;

   modport source (output valid, found_kind, found_author, found_stamp,
                   overlap_seen, overflow, entries_used, input ready);
   modport sink   (input valid, found_kind, found_author, found_stamp,
                   overlap_seen, overflow, entries_used, output ready);
endinterface

### rtl/interval_attribute_table.sv
// ----------------------------------------------------------------------------
// interval_attribute_table
// Sorted table of attributed half-open position ranges with set, insert,
// erase, lookup and overlap test requests.
// ----------------------------------------------------------------------------
// One request is handled at a time: req_ch is ready only while the block is
// idle, and each request gives one response transaction. The work runs on a
// scratch copy of the table, one entry per cycle through a single entry read
// port and one compare/update unit. Lookup and range test walk the entries
// until a hit or the end; set range adds a scan and a tidy pass, insert and
// erase add one bound shift pass over every entry. The tidy pass restarts
// from the first entry after every drop or merge. A refused update leaves
// the committed table untouched.
// ----------------------------------------------------------------------------
module interval_attribute_table import iat_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   iat_req_if.sink   req_ch,
   iat_rsp_if.source rsp_ch
);

   typedef enum logic [3:0] {
      S_IDLE, S_SHIFT_UP, S_SHIFT_DN, S_SCAN, S_SPLIT, S_NEW, S_POST,
      S_TIDY_A, S_TIDY_B, S_LOOK, S_TEST, S_FINISH, S_RESP
   } state_type;

   typedef enum logic [2:0] {
      W_NONE, W_LOAD, W_WRITE, W_INSERT, W_DROP, W_MERGE
   } wop_type;

   state_type state_ff, state_in;
   logic [CNT_BITS-1:0]    idx_ff, idx_in;
   logic [CNT_BITS-1:0]    wn_ff, wn_in;
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic [REQ_BITS-1:0]    op_ff, op_in;
   logic [POS_BITS-1:0]    start_ff, start_in;
   logic [POS_BITS-1:0]    end_ff, end_in;
   logic [KIND_BITS-1:0]   kind_ff, kind_in;
   logic [AUTHOR_BITS-1:0] who_ff, who_in;
   logic [STAMP_BITS-1:0]  stamp_ff, stamp_in;
   logic                   refused_ff, refused_in;
   span_type               tail_ff, tail_in;
   span_type               hold_ff, hold_in;
   logic [KIND_BITS-1:0]   fkind_ff, fkind_in;
   logic [AUTHOR_BITS-1:0] fwho_ff, fwho_in;
   logic [STAMP_BITS-1:0]  fstamp_ff, fstamp_in;
   logic                   seen_ff, seen_in;
   logic                   ovf_ff, ovf_in;

   span_type work_ff [MAX_RANGES];
   span_type table_ff [MAX_RANGES];

   wop_type              wop;
   logic [IDX_BITS-1:0]  w_idx;
   span_type             w_val;
   logic                 commit;
   logic [IDX_BITS-1:0]  rd_idx;
   span_type             cur;
   span_type             upd;
   logic                 idx_end;
   logic                 full;
   logic                 alike;
   logic [KIND_BITS-1:0] in_kind;

   // the second tidy step looks at the entry after the held one
   assign rd_idx  = (state_ff == S_TIDY_B) ? idx_ff[IDX_BITS-1:0] + 1'b1
                                           : idx_ff[IDX_BITS-1:0];
   assign cur     = work_ff[rd_idx];
   assign idx_end = (idx_ff >= wn_ff);
   assign full    = (wn_ff >= CNT_BITS'(MAX_RANGES));
   assign alike   = (hold_ff.kind == cur.kind) &&
                    ((hold_ff.kind == KIND_NONE) || (hold_ff.who == cur.who));
   assign in_kind = (req_ch.change_kind == KIND_RESERVED) ? KIND_NONE
                                                           : req_ch.change_kind;

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      wn_in      = wn_ff;
      count_in   = count_ff;
      op_in      = op_ff;
      start_in   = start_ff;
      end_in     = end_ff;
      kind_in    = kind_ff;
      who_in     = who_ff;
      stamp_in   = stamp_ff;
      refused_in = refused_ff;
      tail_in    = tail_ff;
      hold_in    = hold_ff;
      fkind_in   = fkind_ff;
      fwho_in    = fwho_ff;
      fstamp_in  = fstamp_ff;
      seen_in    = seen_ff;
      ovf_in     = ovf_ff;
      wop        = W_NONE;
      w_idx      = idx_ff[IDX_BITS-1:0];
      w_val      = cur;
      commit     = 1'b0;
      upd        = cur;

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               wop        = W_LOAD;
               wn_in      = count_ff;
               idx_in     = '0;
               refused_in = 1'b0;
               op_in      = req_ch.req_type;
               start_in   = req_ch.range_first;
               end_in     = req_ch.range_last;
               kind_in    = in_kind;
               who_in     = req_ch.change_author;
               stamp_in   = req_ch.change_stamp;
               fkind_in   = '0;
               fwho_in    = '0;
               fstamp_in  = '0;
               seen_in    = 1'b0;
               ovf_in     = 1'b0;
               case (req_ch.req_type)
                  REQ_SET: begin
                     // a reversed range collapses to an empty one
                     if (req_ch.range_last < req_ch.range_first)
                        end_in = req_ch.range_first;
                     state_in = S_SCAN;
                  end
                  REQ_INSERT: state_in = S_SHIFT_UP;
                  REQ_ERASE:  state_in = S_SHIFT_DN;
                  REQ_LOOKUP: state_in = S_LOOK;
                  REQ_TEST:   state_in = S_TEST;
                  default:    state_in = S_FINISH;
               endcase
            end
         end
         S_SHIFT_UP: begin
            if (idx_end) begin
               idx_in   = '0;
               end_in   = (start_ff < POS_MAX) ? start_ff + 1'b1 : POS_MAX;
               state_in = S_SCAN;
            end else begin
               if (cur.lo >= start_ff && cur.lo < POS_MAX) upd.lo = cur.lo + 1'b1;
               if (cur.hi > start_ff && cur.hi < POS_MAX)  upd.hi = cur.hi + 1'b1;
               wop    = W_WRITE;
               w_val  = upd;
               idx_in = idx_ff + 1'b1;
            end
         end
         S_SHIFT_DN: begin
            if (idx_end) begin
               idx_in   = '0;
               state_in = S_TIDY_A;
            end else begin
               if (cur.lo > start_ff) upd.lo = cur.lo - 1'b1;
               if (cur.hi > start_ff) upd.hi = cur.hi - 1'b1;
               wop    = W_WRITE;
               w_val  = upd;
               idx_in = idx_ff + 1'b1;
            end
         end
         S_SCAN: begin
            if (idx_end || cur.lo >= start_ff) begin
               state_in = S_NEW;
            end else begin
               idx_in = idx_ff + 1'b1;
               if (cur.hi > start_ff) begin
                  // cut the entry at the new start, keep the part past the end
                  upd.hi = start_ff;
                  wop    = W_WRITE;
                  w_val  = upd;
                  if (cur.hi >= end_ff) begin
                     tail_in    = cur;
                     tail_in.lo = end_ff;
                     state_in   = S_SPLIT;
                  end
               end
            end
         end
         S_SPLIT: begin
            if (full) begin
               refused_in = 1'b1;
               state_in   = S_FINISH;
            end else begin
               wop      = W_INSERT;
               w_val    = tail_ff;
               wn_in    = wn_ff + 1'b1;
               state_in = S_SCAN;
            end
         end
         S_NEW: begin
            state_in = S_POST;
            if (kind_ff != KIND_NONE) begin
               if (full) begin
                  refused_in = 1'b1;
                  state_in   = S_FINISH;
               end else begin
                  wop         = W_INSERT;
                  w_val.lo    = start_ff;
                  w_val.hi    = end_ff;
                  w_val.kind  = kind_ff;
                  w_val.who   = who_ff;
                  w_val.stamp = stamp_ff;
                  wn_in       = wn_ff + 1'b1;
                  idx_in      = idx_ff + 1'b1;
               end
            end
         end
         S_POST: begin
            if (idx_end) begin
               idx_in   = '0;
               state_in = S_TIDY_A;
            end else if (cur.lo >= start_ff && cur.hi <= end_ff) begin
               wop   = W_DROP;
               wn_in = wn_ff - 1'b1;
            end else begin
               if (cur.lo < end_ff) begin
                  upd.lo = end_ff;
                  wop    = W_WRITE;
                  w_val  = upd;
               end
               idx_in   = '0;
               state_in = S_TIDY_A;
            end
         end
         S_TIDY_A: begin
            if (idx_end) begin
               state_in = S_FINISH;
            end else if (cur.lo == cur.hi) begin
               wop    = W_DROP;
               wn_in  = wn_ff - 1'b1;
               idx_in = '0;
            end else if (idx_ff + 1'b1 >= wn_ff) begin
               state_in = S_FINISH;
            end else begin
               hold_in  = cur;
               state_in = S_TIDY_B;
            end
         end
         S_TIDY_B: begin
            state_in = S_TIDY_A;
            if (alike && hold_ff.hi == cur.lo) begin
               // join with the next entry, keep the later stamp
               upd.lo = hold_ff.lo;
               if (hold_ff.stamp > cur.stamp) upd.stamp = hold_ff.stamp;
               wop    = W_MERGE;
               w_idx  = idx_ff[IDX_BITS-1:0];
               w_val  = upd;
               wn_in  = wn_ff - 1'b1;
               idx_in = '0;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_LOOK: begin
            if (idx_end) begin
               state_in = S_FINISH;
            end else if (cur.lo <= start_ff && start_ff < cur.hi) begin
               fkind_in  = cur.kind;
               fwho_in   = cur.who;
               fstamp_in = cur.stamp;
               state_in  = S_FINISH;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_TEST: begin
            if (idx_end) begin
               state_in = S_FINISH;
            end else if (start_ff < cur.hi && end_ff > cur.lo) begin
               seen_in  = 1'b1;
               state_in = S_FINISH;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_FINISH: begin
            if (op_ff == REQ_SET || op_ff == REQ_INSERT || op_ff == REQ_ERASE) begin
               if (refused_ff) begin
                  ovf_in = 1'b1;
               end else begin
                  commit   = 1'b1;
                  count_in = wn_ff;
               end
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ch.ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         idx_ff     <= '0;
         wn_ff      <= '0;
         count_ff   <= '0;
         op_ff      <= '0;
         refused_ff <= 1'b0;
         fkind_ff   <= '0;
         fwho_ff    <= '0;
         fstamp_ff  <= '0;
         seen_ff    <= 1'b0;
         ovf_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         wn_ff      <= wn_in;
         count_ff   <= count_in;
         op_ff      <= op_in;
         refused_ff <= refused_in;
         fkind_ff   <= fkind_in;
         fwho_ff    <= fwho_in;
         fstamp_ff  <= fstamp_in;
         seen_ff    <= seen_in;
         ovf_ff     <= ovf_in;
      end
      start_ff <= start_in;
      end_ff   <= end_in;
      kind_ff  <= kind_in;
      who_ff   <= who_in;
      stamp_ff <= stamp_in;
      tail_ff  <= tail_in;
      hold_ff  <= hold_in;
   end

   // scratch copy: each entry only looks at itself, its two neighbors and its table entry
   always_ff @(posedge clock) begin
      for (int j = 0; j < MAX_RANGES; j++) begin
         case (wop)
            W_LOAD:  work_ff[j] <= table_ff[j];
            W_WRITE: begin
               if (IDX_BITS'(j) == w_idx) work_ff[j] <= w_val;
            end
            W_INSERT: begin
               if (IDX_BITS'(j) == w_idx)     work_ff[j] <= w_val;
               else if (IDX_BITS'(j) > w_idx) work_ff[j] <= work_ff[(j > 0) ? j - 1 : 0];
            end
            W_DROP: begin
               if (IDX_BITS'(j) >= w_idx && j < MAX_RANGES - 1)
                  work_ff[j] <= work_ff[j + 1];
            end
            W_MERGE: begin
               if (IDX_BITS'(j) == w_idx) work_ff[j] <= w_val;
               else if (IDX_BITS'(j) > w_idx && j < MAX_RANGES - 1)
                  work_ff[j] <= work_ff[j + 1];
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         for (int j = 0; j < MAX_RANGES; j++) table_ff[j] <= work_ff[j];
      end
   end

   assign req_ch.ready        = (state_ff == S_IDLE);
   assign rsp_ch.valid        = (state_ff == S_RESP);
   assign rsp_ch.found_kind   = fkind_ff;
   assign rsp_ch.found_author = fwho_ff;
   assign rsp_ch.found_stamp  = fstamp_ff;
   assign rsp_ch.overlap_seen = seen_ff;
   assign rsp_ch.overflow     = ovf_ff;
   assign rsp_ch.entries_used = count_ff;

   a_wn_bound: assert property (@(posedge clock) disable iff (reset)
      wn_ff <= CNT_BITS'(MAX_RANGES))
      else $error("scratch entry count beyond capacity");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(MAX_RANGES))
      else $error("table entry count beyond capacity");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_ch.valid))
      else $error("request taken while a response is pending");

   a_refused_keeps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && refused_ff) |=> $stable(count_ff))
      else $error("refused update changed the table");

   a_ovf_only_update: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.overflow) |-> (!rsp_ch.overlap_seen &&
         rsp_ch.found_kind == KIND_NONE))
      else $error("overflow flagged on a query");

endmodule
